@@ design/imucf_pkg.sv @@
// Package with shared widths, constants and the arctangent table of the IMU filter.
`default_nettype none
package imucf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int IT_W         = $clog2(CORDIC_STEPS);
  localparam int RAW_W        = 16;
  localparam int CW           = 36;   // CORDIC x/y datapath width
  localparam int ZW           = 27;   // CORDIC angle accumulator width
  localparam int EST_W        = 25;   // roll/pitch estimate width
  localparam int YAW_W        = 32;
  localparam int INC_W        = 26;   // gyro increment width
  localparam int WT_W         = 17;
  localparam logic [WT_W-1:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [WT_W-1:0] WEIGHT_RESET = 17'd64225;
  localparam logic signed [ZW-1:0] HALF_TURN = 27'sd11796480;
  localparam logic [15:0] INV_GAIN = 16'd39797;
  localparam logic [9:0]  DIV_BY   = 10'd262;

  // atan(2^-i) in degrees with 16 fractional bits.
  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0: r = 27'sd2949120;
      5'd1: r = 27'sd1740967;
      5'd2: r = 27'sd919879;
      5'd3: r = 27'sd466945;
      5'd4: r = 27'sd234379;
      5'd5: r = 27'sd117304;
      5'd6: r = 27'sd58666;
      5'd7: r = 27'sd29335;
      5'd8: r = 27'sd14668;
      5'd9: r = 27'sd7334;
      5'd10: r = 27'sd3667;
      5'd11: r = 27'sd1833;
      5'd12: r = 27'sd917;
      5'd13: r = 27'sd458;
      5'd14: r = 27'sd229;
      5'd15: r = 27'sd115;
      5'd16: r = 27'sd57;
      5'd17: r = 27'sd29;
      5'd18: r = 27'sd14;
      5'd19: r = 27'sd7;
      5'd20: r = 27'sd4;
      5'd21: r = 27'sd2;
      5'd22: r = 27'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/imucf_in_if.sv @@
// Input channel interface carrying one raw IMU sample word.
`default_nettype none
interface imucf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic        [15:0] time_step;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  time_step, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                time_step, output ready);
endinterface
`default_nettype wire

@@ design/imucf_out_if.sv @@
// Output channel interface carrying one filtered attitude word.
`default_nettype none
interface imucf_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] roll_angle;
  logic signed [24:0] pitch_angle;
  logic signed [31:0] yaw_angle;
  logic               yaw_clipped;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, yaw_clipped,
                  input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, yaw_clipped,
                output ready);
endinterface
`default_nettype wire

@@ design/imucf_div_lane.sv @@
// Bit-serial gyro increment lane: rounded raw*dt/(131*2^16) scaled to 16 fraction bits.
`default_nettype none
module imucf_div_lane
  import imucf_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [RAW_W-1:0] raw_i,
  input  wire logic        [15:0]      dt_i,
  output logic                         busy_o,
  output logic signed [INC_W-1:0]      inc_o
);

  logic [32:0] num_q, num_d;
  logic [8:0]  rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;

  logic signed [32:0] prod;
  logic        [31:0] prod_abs;
  logic        [9:0]  trial;
  logic        [24:0] quo;

  // Rounded quotient equals floor((2|n| + 131) / 262); one quotient bit per cycle.
  always_comb begin
    prod     = raw_i * $signed({1'b0, dt_i});
    prod_abs = prod[32] ? 32'(-prod) : prod[31:0];
    trial    = {rem_q, num_q[32]};
    num_d = num_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    if (start_i) begin
      num_d = {prod_abs, 1'b0} + 33'd131;
      rem_d = '0;
      cnt_d = 6'd33;
      neg_d = prod[32];
    end else if (cnt_q != '0) begin
      if (trial >= DIV_BY) begin
        rem_d = 9'(trial - DIV_BY);
        num_d = {num_q[31:0], 1'b1};
      end else begin
        rem_d = trial[8:0];
        num_d = {num_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign quo    = num_q[24:0];
  assign busy_o = (cnt_q != '0);
  assign inc_o  = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule
`default_nettype wire

@@ design/imucf_core.sv @@
// One registered CORDIC vectoring micro-rotation stage of the IMU filter.
`default_nettype none
module imucf_core
  import imucf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire logic                 en_i,
  input  wire logic [IT_W-1:0]      it_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  input  wire logic signed [ZW-1:0] z_i,
  output logic signed [CW-1:0]      x_o,
  output logic signed [CW-1:0]      y_o,
  output logic signed [ZW-1:0]      z_o
);
  // One CORDIC vectoring micro-rotation per cycle while en_i is high, registered.
  // A load takes the pass start values unrotated.
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] ang;

  always_comb begin
    ang = atan_deg(5'(it_i));
    dx  = y_i >>> it_i;
    dy  = x_i >>> it_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_o <= '0;
      y_o <= '0;
      z_o <= '0;
    end else if (load_i) begin
      x_o <= x_i;
      y_o <= y_i;
      z_o <= z_i;
    end else if (en_i) begin
      if (!y_i[CW-1]) begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + ang;
      end else begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - ang;
      end
    end
  end
endmodule
`default_nettype wire

@@ design/imu_complementary_filter_core.sv @@
// Top level of the fixed-point IMU complementary filter (roll, pitch, yaw).
`default_nettype none
// One word in gives one word out. An accepted sample is processed alone: two
// CORDIC vectoring passes of 16 micro-rotations each (roll tilt from accel y/z,
// then pitch tilt from -accel x against the gain-corrected magnitude) run one
// rotation per cycle, while three bit-serial lanes form the gyro increments one
// quotient bit per cycle alongside. A shared 18x32 multiplier then blends roll
// and pitch. An item goes through the two passes with the gain step and the
// second pass set-up between them, a wait that collects the gyro increments,
// the blend and the load of the output register; the gyro lanes finish before
// the passes do. A new sample is accepted only in idle, once the previous
// result has moved into the output register. The result sits in that register,
// so the next sample is taken while it waits, and the block stalls only when a
// new result is ready before the old one has been taken. blend_weight is written
// through cfg_we_i/cfg_wdata_i; the user must write it only while the block is
// idle, which the block does not enforce; values above 65536 act as 65536.
module imu_complementary_filter_core
  import imucf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [WT_W-1:0]  cfg_wdata_i,
  imucf_in_if.sink              in_ch,
  imucf_out_if.source           out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_CORD, S_GAIN, S_INIT2, S_WAIT, S_MUL1, S_MUL2, S_ADD, S_SAT, S_DONE
  } state_e;

  state_e state_q;
  logic              pass_q, sel_q, zero_q;
  logic [IT_W-1:0]   it_q;
  logic [WT_W-1:0]   bw_q;
  logic signed [RAW_W-1:0] ax_q;
  logic signed [CW-1:0]    mag_q;
  logic signed [ZW-1:0]    roll_tilt_q;
  logic signed [EST_W-1:0] roll_q, pitch_q;
  logic signed [YAW_W-1:0] yaw_q;
  logic                    clip_q;
  logic signed [YAW_W-1:0] pred_r_q, pred_p_q;
  logic signed [49:0]      prod_q;
  logic signed [50:0]      sum_q;

  // Rotation unit signals.
  logic                 rot_en, load;
  logic signed [CW-1:0] rx, ry, src_x, src_y, ix, iy;
  logic signed [ZW-1:0] rz, iz;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic                 izero;
  logic signed [ZW-1:0] pitch_tilt;

  // Gyro lanes.
  logic start;
  logic busy_x, busy_y, busy_z;
  logic signed [INC_W-1:0] inc_x, inc_y, inc_z;

  logic accept;
  logic emit;
  logic [WT_W-1:0] alpha, beta;
  logic signed [52:0] gain_prod;
  logic signed [32:0] sum_r, sum_p, sum_yaw;
  logic signed [34:0] blended;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_q == S_IDLE);
  assign start        = accept;
  assign alpha        = (bw_q > WEIGHT_ONE) ? WEIGHT_ONE : bw_q;
  assign beta         = WEIGHT_ONE - alpha;
  // The finished word moves into the output register once that register is free.
  assign emit         = (state_q == S_DONE) && (!out_ch.valid || out_ch.ready);

  // Pass set-up: a zero vector is flagged, a left half-plane vector is turned by 180 degrees.
  always_comb begin
    if (state_q == S_IDLE) begin
      src_x = CW'(in_ch.accel_z) <<< 16;
      src_y = CW'(in_ch.accel_y) <<< 16;
    end else begin
      src_x = mag_q;
      src_y = -(CW'(ax_q) <<< 16);
    end
    izero = (src_x == '0) && (src_y == '0);
    if (src_x[CW-1]) begin
      ix = -src_x;
      iy = -src_y;
      iz = src_y[CW-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      ix = src_x;
      iy = src_y;
      iz = '0;
    end
  end

  assign load   = accept || (state_q == S_INIT2);
  assign rot_en = (state_q == S_CORD);

  // The rotation unit takes the pass set-up values on a load and otherwise
  // keeps turning its own registered x/y/z.
  assign cx = load ? ix : rx;
  assign cy = load ? iy : ry;
  assign cz = load ? iz : rz;

  imucf_core u_rot (
    .clk_i (clk_i), .rst_ni (rst_ni), .load_i (load), .en_i (rot_en), .it_i (it_q),
    .x_i (cx), .y_i (cy), .z_i (cz),
    .x_o (rx), .y_o (ry), .z_o (rz)
  );

  // The pitch pass result still sits in the rotation unit during the blend.
  assign pitch_tilt = zero_q ? '0 : rz;

  imucf_div_lane u_lane_x (.clk_i, .rst_ni, .start_i (start), .raw_i (in_ch.gyro_x),
                           .dt_i (in_ch.time_step), .busy_o (busy_x), .inc_o (inc_x));
  imucf_div_lane u_lane_y (.clk_i, .rst_ni, .start_i (start), .raw_i (in_ch.gyro_y),
                           .dt_i (in_ch.time_step), .busy_o (busy_y), .inc_o (inc_y));
  imucf_div_lane u_lane_z (.clk_i, .rst_ni, .start_i (start), .raw_i (in_ch.gyro_z),
                           .dt_i (in_ch.time_step), .busy_o (busy_z), .inc_o (inc_z));

  always_comb begin
    gain_prod = rx * $signed({1'b0, INV_GAIN});
    sum_r     = 33'(roll_q) + 33'(inc_x);
    sum_p     = 33'(pitch_q) + 33'(inc_y);
    sum_yaw   = 33'(yaw_q) + 33'(inc_z);
    blended   = 35'(sum_q >>> 16);
  end

  function automatic logic signed [YAW_W-1:0] sat32(input logic signed [32:0] v);
    logic signed [YAW_W-1:0] r;
    if (v > 33'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (v < -33'sh0_8000_0000) r = 32'sh8000_0000;
    else                            r = v[31:0];
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pass_q   <= 1'b0;
      sel_q    <= 1'b0;
      it_q     <= '0;
      bw_q     <= WEIGHT_RESET;
      roll_q   <= '0;
      pitch_q  <= '0;
      yaw_q    <= '0;
      clip_q   <= 1'b0;
      pred_r_q <= '0;
      pred_p_q <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bw_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            pass_q  <= 1'b0;
            it_q    <= '0;
            state_q <= S_CORD;
          end
        end
        S_CORD: begin
          it_q <= it_q + 1'b1;
          if (it_q == IT_W'(CORDIC_STEPS - 1)) begin
            state_q <= pass_q ? S_WAIT : S_GAIN;
          end
        end
        S_GAIN: begin
          state_q <= S_INIT2;
        end
        S_INIT2: begin
          pass_q  <= 1'b1;
          it_q    <= '0;
          state_q <= S_CORD;
        end
        S_WAIT: begin
          if (!busy_x && !busy_y && !busy_z) begin
            pred_r_q <= sat32(sum_r);
            pred_p_q <= sat32(sum_p);
            yaw_q    <= sat32(sum_yaw);
            clip_q   <= (33'(sat32(sum_yaw)) != sum_yaw);
            sel_q    <= 1'b0;
            state_q  <= S_MUL1;
          end
        end
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_ADD;
        S_ADD:  state_q <= S_SAT;
        S_SAT: begin
          if (sel_q) begin
            state_q <= S_DONE;
          end else begin
            sel_q   <= 1'b1;
            state_q <= S_MUL1;
          end
          if (blended > 35'(HALF_TURN)) begin
            if (sel_q) pitch_q <= EST_W'(HALF_TURN); else roll_q <= EST_W'(HALF_TURN);
          end else if (blended < -35'(HALF_TURN)) begin
            if (sel_q) pitch_q <= -EST_W'(HALF_TURN); else roll_q <= -EST_W'(HALF_TURN);
          end else begin
            if (sel_q) pitch_q <= blended[EST_W-1:0]; else roll_q <= blended[EST_W-1:0];
          end
        end
        S_DONE: begin
          if (emit) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q   <= in_ch.accel_x;
      zero_q <= izero;
    end else if (state_q == S_INIT2) begin
      zero_q <= izero;
    end
    if (state_q == S_GAIN) begin
      roll_tilt_q <= zero_q ? '0 : rz;
      mag_q       <= CW'((gain_prod + 53'sd32768) >>> 16);
    end
    case (state_q)
      S_MUL1: prod_q <= $signed({1'b0, alpha}) * (sel_q ? pred_p_q : pred_r_q);
      S_MUL2: begin
        sum_q  <= 51'(prod_q);
        prod_q <= 50'($signed({1'b0, beta}) * (sel_q ? pitch_tilt : roll_tilt_q));
      end
      S_ADD:  sum_q <= sum_q + 51'(prod_q) + 51'sd32768;
      default: ;
    endcase
    if (emit) begin
      out_ch.roll_angle  <= roll_q;
      out_ch.pitch_angle <= pitch_q;
      out_ch.yaw_angle   <= yaw_q;
      out_ch.yaw_clipped <= clip_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_CORD && !pass_q)
    else $error("accepted word did not start the roll pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.roll_angle <= 25'(HALF_TURN) &&
                     out_ch.roll_angle >= -25'(HALF_TURN))
    else $error("roll output beyond half turn");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.yaw_clipped) |->
      (out_ch.yaw_angle == 32'sh7FFF_FFFF || out_ch.yaw_angle == 32'sh8000_0000))
    else $error("yaw flagged as clipped away from its limits");

endmodule
`default_nettype wire

@@ dv/imu_complementary_filter_core_tb.sv @@
// Self-checking testbench of the IMU complementary filter core.
`timescale 1ns / 1ps
module imu_complementary_filter_core_tb;
  import imucf_pkg::*;

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
    logic        [15:0] dt;
  } sample_t;

  typedef struct {
    logic signed [24:0] roll;
    logic signed [24:0] pitch;
    logic signed [31:0] yaw;
    logic               clipped;
  } attitude_t;

  // The arctangent steps in degrees with 24 fractional bits; the predictor rounds
  // them to 16 fractional bits itself.
  localparam longint ATAN_Q24 [16] = '{
    754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335
  };
  localparam longint ANGLE_LIMIT = 64'sd180 <<< 16;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint I32_MAX = 64'sd2147483647;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [WT_W-1:0] cfg_wdata_i = '0;

  imucf_in_if  in_ch ();
  imucf_out_if out_ch ();

  imu_complementary_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: our own copy of the three estimates and the gyro weight.
  longint roll_est, pitch_est, yaw_est;
  logic [WT_W-1:0] gyro_weight;

  sample_t   pending_samples[$];
  attitude_t expected_attitudes[$];
  int        mismatch_count = 0;
  bit        failed = 1'b0;

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Vectoring CORDIC pass: returns the angle of (x, y) and the scaled length.
  function automatic longint tilt_angle(longint x, longint y, output longint len);
    longint z, dx, dy, step;
    z = 0;
    if (x == 0 && y == 0) begin
      len = 0;
      return 0;
    end
    if (x < 0) begin
      z = (y >= 0) ? ANGLE_LIMIT : -ANGLE_LIMIT;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      step = (ATAN_Q24[i] + 128) >>> 8;
      if (y >= 0) begin
        x += dx; y -= dy; z += step;
      end else begin
        x -= dx; y += dy; z -= step;
      end
    end
    len = x;
    return z;
  endfunction

  // Rate times time step, scaled to degrees, rounded half away from zero.
  function automatic longint rate_to_degrees(longint raw, longint dt);
    longint num;
    longint unsigned m, d, q;
    num = raw * dt;
    m = (num < 0) ? -num : num;
    m = m << 16;
    d = 64'd131 << 16;
    q = (m + d / 2) / d;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint fuse_angle(longint est, longint inc, longint acc, longint a);
    longint pred, v;
    pred = clamp64(est + inc, I32_MIN, I32_MAX);
    v = (a * pred + (64'sd65536 - a) * acc + 32768) >>> 16;
    return clamp64(v, -ANGLE_LIMIT, ANGLE_LIMIT);
  endfunction

  function automatic attitude_t predict_attitude(sample_t s);
    attitude_t r;
    longint a, len, len2, roll_tilt, pitch_tilt, yaw_sum, yaw_new;
    a = (gyro_weight > WEIGHT_ONE) ? 64'sd65536 : longint'(gyro_weight);
    roll_tilt = tilt_angle(longint'(s.az) * 65536, longint'(s.ay) * 65536, len);
    len = (len * 39797 + 32768) >>> 16;
    pitch_tilt = tilt_angle(len, -longint'(s.ax) * 65536, len2);
    roll_est  = fuse_angle(roll_est, rate_to_degrees(s.gx, s.dt), roll_tilt, a);
    pitch_est = fuse_angle(pitch_est, rate_to_degrees(s.gy, s.dt), pitch_tilt, a);
    yaw_sum = yaw_est + rate_to_degrees(s.gz, s.dt);
    yaw_new = clamp64(yaw_sum, I32_MIN, I32_MAX);
    yaw_est = yaw_new;
    r.roll = roll_est[24:0];
    r.pitch = pitch_est[24:0];
    r.yaw = yaw_new[31:0];
    r.clipped = (yaw_new != yaw_sum);
    return r;
  endfunction

  // Sender: bursts of random length, then random gaps. A word is predicted at
  // the edge where it is accepted, using the bus values that were accepted.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t s;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s.ax = in_ch.accel_x; s.ay = in_ch.accel_y; s.az = in_ch.accel_z;
        s.gx = in_ch.gyro_x;  s.gy = in_ch.gyro_y;  s.gz = in_ch.gyro_z;
        s.dt = in_ch.time_step;
        expected_attitudes.push_back(predict_attitude(s));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          s = pending_samples.pop_front();
          in_ch.accel_x <= s.ax; in_ch.accel_y <= s.ay; in_ch.accel_z <= s.az;
          in_ch.gyro_x  <= s.gx; in_ch.gyro_y  <= s.gy; in_ch.gyro_z  <= s.gz;
          in_ch.time_step <= s.dt;
          in_ch.valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: rx_cycle counts clocks and sets when a new stall style is drawn; one style never stalls.
  int rx_cycle = 0;
  int rx_style = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_style = $urandom_range(0, 3);
      case (rx_style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= (rx_cycle % 11) < 3;
        default: out_ch.ready <= (rx_cycle % 40) >= 30;
      endcase
    end
  end

  // Checker: every accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    attitude_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_attitudes.size() == 0) begin
        failed = 1'b1;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result word with nothing expected at %0t", $realtime);
      end else begin
        e = expected_attitudes.pop_front();
        if (out_ch.roll_angle !== e.roll || out_ch.pitch_angle !== e.pitch ||
            out_ch.yaw_angle !== e.yaw || out_ch.yaw_clipped !== e.clipped) begin
          failed = 1'b1;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d clip %0b/%0b (exp/got)",
                     e.roll, out_ch.roll_angle, e.pitch, out_ch.pitch_angle,
                     e.yaw, out_ch.yaw_angle, e.clipped, out_ch.yaw_clipped);
        end
      end
    end
  end

  task automatic add_sample(int ax, int ay, int az, int gx, int gy, int gz, int dt);
    sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
    s.dt = 16'(dt);
    pending_samples.push_back(s);
  endtask

  function automatic int any_raw();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return $urandom_range(0, 64) - 32;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Mostly full-range noise, with gentle, realistic tilts mixed in.
  task automatic add_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0)
        add_sample(any_raw(), any_raw(), any_raw(), any_raw(), any_raw(), any_raw(),
                   $urandom_range(0, 65535));
      else
        add_sample($urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000,
                   16384 + $urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                   $urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                   $urandom_range(0, 1300));
    end
  endtask

  // Long pushes of the gyros in one direction drive yaw, and with full gyro
  // weight also roll and pitch, into saturation.
  task automatic add_spin(int count, int dir);
    for (int i = 0; i < count; i++)
      add_sample(any_raw(), any_raw(), any_raw(), dir * (32767 - $urandom_range(0, 200)),
                 dir * (32767 - $urandom_range(0, 200)), dir * (32767 - $urandom_range(0, 99)),
                 65535 - $urandom_range(0, 300));
  endtask

  // Waits for the block to drain, then writes the gyro weight while idle.
  task automatic drain_and_write(logic [WT_W-1:0] w);
    while (pending_samples.size() > 0 || in_ch.valid || expected_attitudes.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gyro_weight = w;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.accel_x = '0; in_ch.accel_y = '0; in_ch.accel_z = '0;
    in_ch.gyro_x = '0;  in_ch.gyro_y = '0;  in_ch.gyro_z = '0;
    in_ch.time_step = '0;
    out_ch.ready = 1'b0;
    roll_est = 0; pitch_est = 0; yaw_est = 0;
    gyro_weight = WEIGHT_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset weight: zero vector, the half-turn cases on
    // either side of the negative x axis, field extremes and zero and full time steps.
    add_sample(0, 0, 0, 0, 0, 0, 0);
    add_sample(0, 0, 16384, 0, 0, 0, 655);
    add_sample(0, 16384, -16384, 131, -131, 131, 65535);
    add_sample(0, -16384, -16384, -131, 131, -131, 65535);
    add_sample(0, 0, -16384, 0, 0, 0, 1);
    add_sample(0, -1, -32768, 0, 0, 0, 1);
    add_sample(16384, 0, 0, 0, 0, 0, 0);
    add_sample(-16384, 0, 0, 0, 0, 0, 0);
    add_sample(-32768, 0, 0, 0, 0, 0, 0);
    add_sample(32767, 32767, 32767, 32767, 32767, 32767, 65535);
    add_sample(-32768, -32768, -32768, -32768, -32768, -32768, 65535);
    add_sample(-32768, 32767, -32768, 32767, -32768, 32767, 0);
    add_sample(32767, -32768, 32767, -32768, 32767, -32768, 32768);
    add_sample(0, 32767, 0, 1, -1, 1, 1);
    add_sample(0, -32768, 0, -1, 1, -1, 65535);

    drain_and_write('0);             // accelerometer only
    add_random(60);
    drain_and_write(17'h1FFFF);      // above one acts as full gyro weight
    add_spin(140, 1);
    drain_and_write(WEIGHT_ONE);
    add_spin(20, -1);
    drain_and_write(17'($urandom_range(0, 65536)));
    add_random(60);
    drain_and_write(17'($urandom_range(65537, 131071)));
    add_random(30);
    drain_and_write(WEIGHT_RESET);
    add_random(80);

    while (pending_samples.size() > 0 || in_ch.valid || expected_attitudes.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (!failed && expected_attitudes.size() == 0) begin
      $display("imu_complementary_filter_core verification clean");
    end else begin
      $display("imu_complementary_filter_core verification failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("imu_complementary_filter_core verification failed");
    $finish;
  end

endmodule
